/* hw/rtl/lcd_smt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline mode timer package
// Timing constants, mode codes, register indexes and the result layout.
// ----------------------------------------------------------------------------
package lcd_smt_pkg;

    localparam int DOTS_PER_LINE = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;
    localparam int OAM_DOTS      = 80;
    localparam int TRANSFER_DOTS = 172;

    localparam int CD_W      = 10;
    localparam int LINE_W    = 8;
    localparam int ELAPSED_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // countdown thresholds that split a visible line into its modes
    localparam int OAM_BOUND  = DOTS_PER_LINE - OAM_DOTS;
    localparam int XFER_BOUND = OAM_BOUND - TRANSFER_DOTS;

    localparam logic signed [CD_W+1:0] OAM_BOUND_S  = (CD_W+2)'(OAM_BOUND);
    localparam logic signed [CD_W+1:0] XFER_BOUND_S = (CD_W+2)'(XFER_BOUND);
    localparam logic [CD_W-1:0]        CD_RELOAD    = CD_W'(DOTS_PER_LINE);
    localparam logic [LINE_W-1:0]      LINE_VBLANK  = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0]      LINE_TOTAL   = LINE_W'(TOTAL_LINES);

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ENABLE = 3'd0,
        REG_LINE_COMPARE   = 3'd1,
        REG_HBLANK_IRQ_EN  = 3'd2,
        REG_VBLANK_IRQ_EN  = 3'd3,
        REG_OAM_IRQ_EN     = 3'd4,
        REG_COIN_IRQ_EN    = 3'd5
    } cfg_reg_t;

    // packed from the top down: current_line sits in the lowest bits
    typedef struct packed {
        logic [1:0]        pad;
        logic              draw_line;
        logic              vblank_irq;
        logic              stat_irq;
        logic              coincidence;
        lcd_mode_t         mode;
        logic [LINE_W-1:0] current_line;
    } result_t;

endpackage

/* hw/rtl/lcd_scanline_mode_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline mode timer
// Tracks dot countdown, line and display mode; flags STAT/vblank/draw events.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one beat per timing step, s_tdata carries elapsed_cycles.
//  m_* channel: one result beat per input beat, in order.
//  cfg_we/cfg_index/cfg_data: register write, taken on any edge with cfg_we
//  high; write only while no beat is in flight. Indexes above 5 are ignored.
//  Result: a result is on m_* in the cycle after its input beat is taken.
//  Throughput: one beat per cycle while m_* is not stalled; the state
//  update for a beat is a single subtract-and-compare on the countdown
//  plus the line increment, done in the cycle the beat is taken.
//  The result register frees s_tready whenever it is empty or being drained,
//  so a stalled receiver holds m_tdata and back-pressures the input only
//  while the result register is full.
//  Reset: configuration registers to zero, countdown to a full line,
//  line 0, mode 0; no result pending. With the display disabled every beat
//  yields an all-zero result and puts the counters back to their reset values.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_unit
    import lcd_smt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] elapsed_cycles
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] current_line, [9:8] mode, [10] coincidence, [11] stat_irq,
    // [12] vblank_irq, [13] draw_line, [15:14] zero
    output logic [15:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic              disp_en_reg;
    logic [LINE_W-1:0] line_cmp_reg;
    logic              hblank_ie_reg;
    logic              vblank_ie_reg;
    logic              oam_ie_reg;
    logic              coin_ie_reg;

    logic [CD_W-1:0]   dot_countdown_reg, dot_countdown_next;
    logic [LINE_W-1:0] line_counter_reg, line_counter_next;
    lcd_mode_t         last_mode_reg, last_mode_next;

    logic              m_tvalid_reg;
    result_t           result_reg, result_next;

    logic                   accept;
    logic signed [CD_W+1:0] cd_ext;
    logic signed [CD_W+1:0] cd_left;
    logic                   cd_expired;
    logic [LINE_W-1:0]      line_inc;
    lcd_mode_t              mode_cur;
    logic                   mode_ie;
    logic                   coin;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_en_reg   <= 1'b0;
            line_cmp_reg  <= '0;
            hblank_ie_reg <= 1'b0;
            vblank_ie_reg <= 1'b0;
            oam_ie_reg    <= 1'b0;
            coin_ie_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISPLAY_ENABLE: disp_en_reg   <= cfg_data[0];
                REG_LINE_COMPARE:   line_cmp_reg  <= cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:  hblank_ie_reg <= cfg_data[0];
                REG_VBLANK_IRQ_EN:  vblank_ie_reg <= cfg_data[0];
                REG_OAM_IRQ_EN:     oam_ie_reg    <= cfg_data[0];
                REG_COIN_IRQ_EN:    coin_ie_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cd_ext     = $signed({2'b00, dot_countdown_reg});
        cd_left    = cd_ext - $signed({{(CD_W+2-ELAPSED_W){1'b0}}, s_tdata});
        cd_expired = (cd_left <= 0);
        line_inc   = line_counter_reg + LINE_W'(1);

        // mode comes from the state before this step
        priority if (line_counter_reg >= LINE_VBLANK)
        begin
            mode_cur = MODE_VBLANK;
            mode_ie  = vblank_ie_reg;
        end
        else if (cd_ext >= OAM_BOUND_S)
        begin
            mode_cur = MODE_OAM;
            mode_ie  = oam_ie_reg;
        end
        else if (cd_ext >= XFER_BOUND_S)
        begin
            mode_cur = MODE_TRANSFER;
            mode_ie  = 1'b0;
        end
        else
        begin
            mode_cur = MODE_HBLANK;
            mode_ie  = hblank_ie_reg;
        end

        coin = (line_counter_reg == line_cmp_reg);

        result_next        = '0;
        dot_countdown_next = CD_RELOAD;
        line_counter_next  = '0;
        last_mode_next     = MODE_HBLANK;

        if (disp_en_reg)
        begin
            last_mode_next          = mode_cur;
            result_next.mode        = mode_cur;
            result_next.coincidence = coin;
            result_next.stat_irq    = (mode_ie && (mode_cur != last_mode_reg))
                                   || (coin && coin_ie_reg);
            line_counter_next       = line_counter_reg;
            if (cd_expired)
            begin
                line_counter_next = line_inc;
                if (line_inc == LINE_VBLANK)
                    result_next.vblank_irq = 1'b1;
                else if (line_inc >= LINE_TOTAL)
                    line_counter_next = '0;
                else if (line_inc < LINE_VBLANK)
                    result_next.draw_line = 1'b1;
            end
            else
            begin
                dot_countdown_next = cd_left[CD_W-1:0];
            end
            result_next.current_line = line_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_countdown_reg <= CD_RELOAD;
            line_counter_reg  <= '0;
            last_mode_reg     <= MODE_HBLANK;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                dot_countdown_reg <= dot_countdown_next;
                line_counter_reg  <= line_counter_next;
                last_mode_reg     <= last_mode_next;
                m_tvalid_reg      <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !disp_en_reg) |=> (m_tvalid && (m_tdata == '0)))
        else $error("display off did not give an all-zero result");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_counter_reg < LINE_TOTAL)
        else $error("line counter beyond last line");

    a_cd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dot_countdown_reg != '0) && (dot_countdown_reg <= CD_RELOAD))
        else $error("dot countdown out of range");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result_reg.vblank_irq && result_reg.draw_line))
        else $error("vblank and draw flagged on the same beat");
`endif

endmodule

/* tb/tb_lcd_scanline_mode_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LCD scanline mode timer
// A scoreboard built into the bench tracks the dot countdown, line counter
// and mode for each accepted step. Every result beat is checked field by
// field against the oldest prediction. Directed steps cover display off, the
// mode boundaries, overshoot and ignored register indexes. Random phases then
// walk whole frames under several register settings. Both stream sides stall
// at random, with one long output stall and repeated full drain pauses.
// ----------------------------------------------------------------------------
module tb_lcd_scanline_mode_timer_unit;
    import lcd_smt_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 120;

    // register slots the block has to ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] elapsed_cycles
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] current_line, [9:8] mode, [10] coincidence, [11] stat_irq,
    // [12] vblank_irq, [13] draw_line, [15:14] zero
    logic [15:0]          m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // scoreboard copy of the timer state and registers
    int                dots_left = DOTS_PER_LINE;
    logic [LINE_W-1:0] line_no   = '0;
    lcd_mode_t         prev_mode = MODE_HBLANK;
    logic              lcd_on    = 1'b0;
    logic [7:0]        cmp_line  = '0;
    logic              hblank_en = 1'b0;
    logic              vblank_en = 1'b0;
    logic              oam_en    = 1'b0;
    logic              coin_en   = 1'b0;

    result_t pending_results[$];
    int      mismatches   = 0;
    int      beats_seen   = 0;
    int      stall_cycles = 0;
    bit      tx_idle_on   = 1'b0;
    bit      rx_idle_on   = 1'b0;
    bit      rx_hold_req  = 1'b0;

    lcd_scanline_mode_timer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_DISPLAY_ENABLE: lcd_on    = val[0];
            REG_LINE_COMPARE:   cmp_line  = val;
            REG_HBLANK_IRQ_EN:  hblank_en = val[0];
            REG_VBLANK_IRQ_EN:  vblank_en = val[0];
            REG_OAM_IRQ_EN:     oam_en    = val[0];
            REG_COIN_IRQ_EN:    coin_en   = val[0];
            default: ;
        endcase
    endfunction

    // one timing step: mode from the old state, then countdown and line
    function automatic result_t next_scanline_result(input logic [ELAPSED_W-1:0] elapsed);
        result_t   res;
        lcd_mode_t cur_mode;
        logic      irq_sel;
        int        remaining;
        res      = '0;
        cur_mode = MODE_HBLANK;
        irq_sel  = 1'b0;
        if (!lcd_on)
        begin
            dots_left = DOTS_PER_LINE;
            line_no   = '0;
            prev_mode = MODE_HBLANK;
        end
        else
        begin
            if (line_no >= VISIBLE_LINES)
            begin
                cur_mode = MODE_VBLANK;
                irq_sel  = vblank_en;
            end
            else if (dots_left >= OAM_BOUND)
            begin
                cur_mode = MODE_OAM;
                irq_sel  = oam_en;
            end
            else if (dots_left >= XFER_BOUND)
                cur_mode = MODE_TRANSFER;
            else
            begin
                cur_mode = MODE_HBLANK;
                irq_sel  = hblank_en;
            end

            if (irq_sel && cur_mode != prev_mode)
                res.stat_irq = 1'b1;
            if (line_no == cmp_line)
            begin
                res.coincidence = 1'b1;
                if (coin_en)
                    res.stat_irq = 1'b1;
            end
            prev_mode = cur_mode;

            // overshoot past zero is dropped on reload
            remaining = dots_left - int'(elapsed);
            if (remaining <= 0)
            begin
                line_no   = line_no + 8'd1;
                remaining = DOTS_PER_LINE;
                if (line_no == VISIBLE_LINES)
                    res.vblank_irq = 1'b1;
                else if (line_no >= TOTAL_LINES)
                    line_no = '0;
                else if (line_no < VISIBLE_LINES)
                    res.draw_line = 1'b1;
            end
            dots_left = remaining;
        end
        res.current_line = line_no;
        res.mode         = cur_mode;
        return res;
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        // mostly long steps so that whole frames go by
        if (roll < 7)
            return ELAPSED_W'($urandom_range(128, 255));
        else if (roll < 9)
            return ELAPSED_W'($urandom);
        else
            return ELAPSED_W'($urandom_range(0, 7));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("MISMATCH beat %0d %s: expected %h, got %h", beats_seen, what, want, got);
        mismatches++;
    endtask

    // leaves tvalid high; the caller lowers it or offers the next beat
    task automatic send_step(input logic [ELAPSED_W-1:0] elapsed);
        s_tvalid <= 1'b1;
        s_tdata  <= elapsed;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(next_scanline_result(elapsed));
    endtask

    task automatic feed(input logic [ELAPSED_W-1:0] elapsed);
        send_step(elapsed);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high so back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic configure(input logic on, input logic [7:0] cmp, input logic hb,
                             input logic vb, input logic oam, input logic coin);
        drain_results();
        @(posedge clk);
        // junk in the upper bits of the flag registers must be masked off
        write_reg(REG_DISPLAY_ENABLE, {7'($urandom), on});
        write_reg(REG_LINE_COMPARE,   cmp);
        write_reg(REG_HBLANK_IRQ_EN,  {7'($urandom), hb});
        write_reg(REG_VBLANK_IRQ_EN,  {7'($urandom), vb});
        write_reg(REG_OAM_IRQ_EN,     {7'($urandom), oam});
        write_reg(REG_COIN_IRQ_EN,    {7'($urandom), coin});
        cfg_we <= 1'b0;
    endtask

    task automatic run_steps(input int count);
        repeat (count) feed(pick_elapsed());
    endtask

    task automatic test_display_off();
        feed(8'd0);
        feed(8'd255);
        feed(8'd17);
        configure(1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        feed(8'd255);
        feed(8'd0);
        feed(8'd200);
    endtask

    // walks OAM, transfer and hblank across their exact boundaries
    task automatic test_mode_walk();
        logic [ELAPSED_W-1:0] walk[$];
        walk = '{8'd0, 8'd80, 8'd0, 8'd1, 8'd0, 8'd171, 8'd0, 8'd1, 8'd0,
                 8'd203, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd127};
        configure(1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        foreach (walk[i])
            feed(walk[i]);
        configure(1'b1, 8'd3, 1'b0, 1'b0, 1'b1, 1'b0);
        repeat (6) feed(8'd255);
    endtask

    task automatic test_unused_indexes();
        drain_results();
        @(posedge clk);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        write_reg(REG_SPARE_HI, 8'hFF);
        cfg_we <= 1'b0;
        repeat (4) feed(8'd255);
    endtask

    task automatic test_receiver_hold();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        configure(1'b1, 8'd5, 1'b1, 1'b1, 1'b1, 1'b1);
        rx_hold_req = 1'b1;
        repeat (12) feed(pick_elapsed());
        drain_results();
    endtask

    task automatic test_sender_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (3)
        begin
            run_steps(8);
            drain_results();
            @(posedge clk);
        end
    endtask

    task automatic test_random_frames();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        configure(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        run_steps(30);
        configure(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        run_steps(150);
        configure(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        run_steps(150);
        repeat (2)
        begin
            configure(1'b1, 8'($urandom_range(0, TOTAL_LINES - 1)), 1'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
            run_steps(150);
        end
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        configure(1'b1, 8'(TOTAL_LINES - 1), 1'b1, 1'($urandom), 1'($urandom), 1'b1);
        run_steps(200);
    endtask

    // output side: random stalls plus one long hold on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            beats_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", 16'h0, m_tdata);
            else
            begin
                want = pending_results.pop_front();
                if (got.current_line !== want.current_line)
                    report_mismatch("current_line", 16'(want.current_line),
                                    16'(got.current_line));
                if (got.mode !== want.mode)
                    report_mismatch("mode", 16'(want.mode), 16'(got.mode));
                if (got.coincidence !== want.coincidence)
                    report_mismatch("coincidence", 16'(want.coincidence),
                                    16'(got.coincidence));
                if (got.stat_irq !== want.stat_irq)
                    report_mismatch("stat_irq", 16'(want.stat_irq), 16'(got.stat_irq));
                if (got.vblank_irq !== want.vblank_irq)
                    report_mismatch("vblank_irq", 16'(want.vblank_irq),
                                    16'(got.vblank_irq));
                if (got.draw_line !== want.draw_line)
                    report_mismatch("draw_line", 16'(want.draw_line), 16'(got.draw_line));
                if (got.pad !== want.pad)
                    report_mismatch("pad bits", 16'(want.pad), 16'(got.pad));
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DISPLAY_ENABLE;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_display_off();
        test_mode_walk();
        test_unused_indexes();
        test_receiver_hold();
        test_sender_pause();
        test_random_frames();

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
